// ===== sv/wrf_pkg.sv =====
// ----------------------------------------------------------------------------
// wrf_pkg
// Shared constants, codes and types of the waypoint route follower.
// ----------------------------------------------------------------------------
package wrf_pkg;

    localparam int WAYPOINTS_DEF  = 64;
    localparam int COORD_BITS_DEF = 24;

    localparam int CORDIC_STEPS = 20;
    localparam int CNT_W        = 5;
    localparam int ACC_W        = 24;
    localparam int HEAD_W       = 15;
    localparam int IDX_W        = 7;
    localparam int CFG_W        = 6;
    localparam int RAD_W        = 16;
    localparam int PRESCALE_SH  = 24;

    localparam logic [1:0] OP_LOAD_PRI = 2'd0;
    localparam logic [1:0] OP_LOAD_SEC = 2'd1;
    localparam logic [1:0] OP_STEP     = 2'd2;
    localparam logic [1:0] OP_NOP      = 2'd3;

    localparam logic [1:0] MODE_PRI      = 2'd0;
    localparam logic [1:0] MODE_SEC      = 2'd1;
    localparam logic [1:0] MODE_DUAL     = 2'd2;
    localparam logic [1:0] MODE_DUAL_ALT = 2'd3;

    localparam logic [1:0] PH_PRI = 2'd0;
    localparam logic [1:0] PH_SEC = 2'd1;
    localparam logic [1:0] PH_RET = 2'd2;

    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_PRI_FIRST = 3'd1;
    localparam logic [2:0] REG_PRI_LAST  = 3'd2;
    localparam logic [2:0] REG_SWITCH    = 3'd3;
    localparam logic [2:0] REG_SEC_FIRST = 3'd4;
    localparam logic [2:0] REG_SEC_LAST  = 3'd5;
    localparam logic [2:0] REG_PRI_RAD   = 3'd6;
    localparam logic [2:0] REG_SEC_RAD   = 3'd7;

    localparam logic signed [ACC_W-1:0] HALF_TURN = 24'sd2949120;
    localparam logic signed [ACC_W-1:0] FULL_TURN = 24'sd5898240;
    localparam logic [HEAD_W-1:0]       HEADING_WRAP = 15'd23040;

    // atan(2^-i) in 1/16384 degree
    localparam logic [19:0] ATAN_UNITS [CORDIC_STEPS] = '{
        20'd737280, 20'd435242, 20'd229970, 20'd116736, 20'd58595,
        20'd29326,  20'd14667,  20'd7334,   20'd3667,   20'd1833,
        20'd917,    20'd458,    20'd229,    20'd115,    20'd57,
        20'd29,     20'd14,     20'd7,      20'd4,      20'd2
    };

    typedef struct packed {
        logic              done;
        logic [HEAD_W-1:0] heading;
    } t_cordic_res;

endpackage

// ===== sv/wrf_cordic.sv =====
// ----------------------------------------------------------------------------
// wrf_cordic
// Iterative vectoring CORDIC: heading of (dx, dy) in 1/64 degree, one
// micro-rotation per cycle.
// ----------------------------------------------------------------------------
module wrf_cordic #(
    parameter int COORD_BITS = wrf_pkg::COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [COORD_BITS:0] i_dx,
    input  logic signed [COORD_BITS:0] i_dy,
    output wrf_pkg::t_cordic_res      o_res
);
    import wrf_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int W  = COORD_BITS + 27;

    logic signed [W-1:0]     r_x, r_y, n_x, n_y, x0, y0, xs, ys;
    logic signed [ACC_W-1:0] r_acc, n_acc, atan_s;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_run, r_post, r_zero, r_done;
    logic [HEAD_W-1:0]       r_head, h_raw, h_fin;
    logic [ACC_W-1:0]        acc_pos, acc_rnd;

    assign x0     = {{(W-DW-PRESCALE_SH){i_dx[DW-1]}}, i_dx, {PRESCALE_SH{1'b0}}};
    assign y0     = {{(W-DW-PRESCALE_SH){i_dy[DW-1]}}, i_dy, {PRESCALE_SH{1'b0}}};
    assign xs     = r_x >>> r_cnt;
    assign ys     = r_y >>> r_cnt;
    assign atan_s = signed'({4'b0, ATAN_UNITS[r_cnt]});

    always_comb begin
        if (!r_y[W-1]) begin
            n_x   = r_x + ys;
            n_y   = r_y - xs;
            n_acc = r_acc + atan_s;
        end else begin
            n_x   = r_x - ys;
            n_y   = r_y + xs;
            n_acc = r_acc - atan_s;
        end
    end

    assign acc_pos = r_acc[ACC_W-1] ? unsigned'(r_acc + FULL_TURN) : unsigned'(r_acc);
    assign acc_rnd = acc_pos + 24'd128;
    assign h_raw   = acc_rnd[22:8];
    assign h_fin   = (h_raw >= HEADING_WRAP) ? h_raw - HEADING_WRAP : h_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_post <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_zero <= (i_dx == '0) && (i_dy == '0);
                r_cnt  <= '0;
                r_run  <= 1'b1;
                if (i_dx[DW-1]) begin
                    r_x   <= -x0;
                    r_y   <= -y0;
                    r_acc <= HALF_TURN;
                end else begin
                    r_x   <= x0;
                    r_y   <= y0;
                    r_acc <= '0;
                end
            end else if (r_run) begin
                r_x   <= n_x;
                r_y   <= n_y;
                r_acc <= n_acc;
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_post <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end else if (r_post) begin
                r_post <= 1'b0;
                r_done <= 1'b1;
                r_head <= r_zero ? '0 : h_fin;
            end
        end
    end

    assign o_res = '{done: r_done, heading: r_head};

endmodule

// ===== sv/waypoint_route_follower_top.sv =====
// ----------------------------------------------------------------------------
// waypoint_route_follower_top
// Two waypoint tables in block memory and a route sequencer that steers
// toward the current waypoint and advances on arrival.
// ----------------------------------------------------------------------------
// Usage:
//   An input word (operation, slot, east/north in mm) is taken when i_start
//   is high and o_busy is low. Every word gives one result word, shown on the
//   o_ ports for one cycle while o_done is high; the receiver cannot stall.
//   Loads, unused codes and steps that do not steer give their result in the
//   cycle after acceptance, and a new word can be taken in that cycle.
//   A steering step passes through one table memory read, one difference
//   stage, 20 CORDIC iterations, one heading wrap and one result register.
//   The distance test runs beside the CORDIC loop on one shared 16x16
//   multiplier, squaring the east offset, the north offset and the radius in turn.
//   Registers are written through i_cfg_we/i_cfg_index/i_cfg_data at any
//   edge; write them only while the block is idle.
//   Reset clears cursors, phase, heading and loads the default registers.
//   Table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module waypoint_route_follower_top #(
    parameter int WAYPOINTS  = wrf_pkg::WAYPOINTS_DEF,
    parameter int COORD_BITS = wrf_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [1:0]                   i_operation,
    input  logic [wrf_pkg::CFG_W-1:0]    i_slot,
    input  logic signed [COORD_BITS-1:0] i_east_mm,
    input  logic signed [COORD_BITS-1:0] i_north_mm,
    input  logic                         i_cfg_we,
    input  logic [2:0]                   i_cfg_index,
    input  logic [wrf_pkg::RAD_W-1:0]    i_cfg_data,
    output logic                         o_done,
    output logic [wrf_pkg::HEAD_W-1:0]   o_heading,
    output logic                         o_halt,
    output logic                         o_arrived,
    output logic [1:0]                   o_leg_phase,
    output logic [wrf_pkg::IDX_W-1:0]    o_primary_index,
    output logic [wrf_pkg::IDX_W-1:0]    o_secondary_index
);
    import wrf_pkg::*;

    localparam int AW = $clog2(WAYPOINTS);
    localparam int DW = COORD_BITS + 1;
    localparam int EW = 2 * COORD_BITS;

    typedef enum logic [1:0] {S_IDLE, S_DIFF, S_RUN} t_state;
    typedef enum logic [2:0] {K_MP, K_MS, K_PH0, K_PH1, K_PH2} t_kind;

    logic [EW-1:0] mem_p [WAYPOINTS];
    logic [EW-1:0] mem_s [WAYPOINTS];
    logic [EW-1:0] r_rd_p, r_rd_s, rd_word;

    t_state            r_state;
    t_kind             r_kind, d_kind;
    logic [1:0]        r_mode, r_phase, n_phase;
    logic [CFG_W-1:0]  r_pf, r_pl, r_sw, r_sf, r_sl;
    logic [RAD_W-1:0]  r_prad, r_srad;
    logic [IDX_W-1:0]  r_pc, r_sc, n_pc, n_sc, sc_inc, sel_cur;
    logic [IDX_W-1:0]  pf7, pl7, sw7, sf7, sl7;
    logic [HEAD_W-1:0] r_heading;
    logic              r_halt, r_arrived, r_done;
    logic              r_sec, r_idx_ok, r_near;
    logic signed [COORD_BITS-1:0] r_px, r_py, wx, wy;
    logic signed [DW-1:0] dx, dy, ax, ay;
    logic [RAD_W-1:0]  r_ax, r_ay, mul_a;
    logic [1:0]        r_mcnt;
    logic [2*RAD_W-1:0] prod, r_r2;
    logic [2*RAD_W:0]  r_sq;
    logic              d_steer, d_sec, d_halt, acc, is_step, slot_ok, idx_ok;
    logic              rd_en, wr_p, wr_s, arr;
    logic [AW-1:0]     wr_addr, rd_addr;
    t_cordic_res       cres;

    assign pf7 = {1'b0, r_pf};
    assign pl7 = {1'b0, r_pl};
    assign sw7 = {1'b0, r_sw};
    assign sf7 = {1'b0, r_sf};
    assign sl7 = {1'b0, r_sl};

    assign acc     = i_start && (r_state == S_IDLE);
    assign is_step = (i_operation == OP_STEP);
    assign slot_ok = 32'(i_slot) < 32'(WAYPOINTS);
    assign wr_addr = AW'(i_slot);
    assign wr_p    = acc && (i_operation == OP_LOAD_PRI) && slot_ok;
    assign wr_s    = acc && (i_operation == OP_LOAD_SEC) && slot_ok;

    // route decision from current cursors and registers
    always_comb begin
        d_steer = 1'b0;
        d_sec   = 1'b0;
        d_halt  = 1'b0;
        d_kind  = K_MP;
        unique case (r_mode)
            MODE_PRI: begin
                if (r_pc > pl7) d_halt = 1'b1;
                else if (pf7 < pl7) d_steer = 1'b1;
            end
            MODE_SEC: begin
                d_sec  = 1'b1;
                d_kind = K_MS;
                if (r_sc > sl7) d_halt = 1'b1;
                else if (sf7 < sl7) d_steer = 1'b1;
            end
            default: begin
                if (r_pc > pl7 && r_sc > sl7) begin
                    d_halt = 1'b1;
                end else if (r_phase == PH_PRI) begin
                    d_kind = K_PH0;
                    if (r_pc <= sw7) d_steer = 1'b1;
                    else d_halt = 1'b1;
                end else if (r_phase == PH_SEC) begin
                    d_kind = K_PH1;
                    d_sec  = 1'b1;
                    if (r_sc <= sl7) d_steer = 1'b1;
                    else d_halt = 1'b1;
                end else begin
                    d_kind = K_PH2;
                    if (r_pc <= pl7) d_steer = 1'b1;
                    else d_halt = 1'b1;
                end
            end
        endcase
    end

    assign sel_cur = d_sec ? r_sc : r_pc;
    assign idx_ok  = 32'(sel_cur) < 32'(WAYPOINTS);
    assign rd_addr = AW'(sel_cur);
    assign rd_en   = acc && is_step && d_steer;

    always_ff @(posedge i_clk) begin
        if (wr_p) mem_p[wr_addr] <= {i_east_mm, i_north_mm};
        if (rd_en) r_rd_p <= mem_p[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (wr_s) mem_s[wr_addr] <= {i_east_mm, i_north_mm};
        if (rd_en) r_rd_s <= mem_s[rd_addr];
    end

    assign rd_word = r_sec ? r_rd_s : r_rd_p;
    assign wx = r_idx_ok ? signed'(rd_word[EW-1:COORD_BITS]) : '0;
    assign wy = r_idx_ok ? signed'(rd_word[COORD_BITS-1:0]) : '0;
    assign dx = DW'(wx) - DW'(r_px);
    assign dy = DW'(wy) - DW'(r_py);
    assign ax = dx[DW-1] ? -dx : dx;
    assign ay = dy[DW-1] ? -dy : dy;

    always_comb begin
        unique case (r_mcnt)
            2'd0:    mul_a = r_ax;
            2'd1:    mul_a = r_ay;
            default: mul_a = r_sec ? r_srad : r_prad;
        endcase
    end
    assign prod = mul_a * mul_a;

    assign arr    = r_near && (r_sq < {1'b0, r_r2});
    assign sc_inc = r_sc + 1'b1;

    always_comb begin
        n_pc    = r_pc;
        n_sc    = r_sc;
        n_phase = r_phase;
        if (arr) begin
            unique case (r_kind)
                K_MP: if (r_pc < pl7) n_pc = r_pc + 1'b1;
                K_MS: n_sc = sc_inc;
                K_PH0: begin
                    if (r_pc == sw7) begin
                        n_phase = PH_SEC;
                        n_sc    = sf7;
                    end
                    n_pc = r_pc + 1'b1;
                end
                K_PH1: begin
                    n_sc = sc_inc;
                    if (sc_inc > sl7) begin
                        n_phase = PH_RET;
                        n_pc    = sw7 + 1'b1;
                    end
                end
                K_PH2:   n_pc = r_pc + 1'b1;
                default: n_pc = r_pc;
            endcase
        end
    end

    wrf_cordic #(.COORD_BITS(COORD_BITS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIFF),
        .i_dx    (dx),
        .i_dy    (dy),
        .o_res   (cres)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_done    <= 1'b0;
            r_halt    <= 1'b0;
            r_arrived <= 1'b0;
            r_pc      <= '0;
            r_sc      <= '0;
            r_phase   <= PH_PRI;
            r_heading <= '0;
            r_mode    <= MODE_DUAL;
            r_pf      <= '0;
            r_pl      <= '0;
            r_sw      <= '0;
            r_sf      <= '0;
            r_sl      <= '0;
            r_prad    <= 16'd1000;
            r_srad    <= 16'd100;
            r_mcnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_MODE:      r_mode <= i_cfg_data[1:0];
                    REG_PRI_FIRST: r_pf   <= i_cfg_data[CFG_W-1:0];
                    REG_PRI_LAST:  r_pl   <= i_cfg_data[CFG_W-1:0];
                    REG_SWITCH:    r_sw   <= i_cfg_data[CFG_W-1:0];
                    REG_SEC_FIRST: r_sf   <= i_cfg_data[CFG_W-1:0];
                    REG_SEC_LAST:  r_sl   <= i_cfg_data[CFG_W-1:0];
                    REG_PRI_RAD:   r_prad <= i_cfg_data;
                    REG_SEC_RAD:   r_srad <= i_cfg_data;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        if (is_step && d_steer) begin
                            r_px     <= i_east_mm;
                            r_py     <= i_north_mm;
                            r_sec    <= d_sec;
                            r_kind   <= d_kind;
                            r_idx_ok <= idx_ok;
                            r_state  <= S_DIFF;
                        end else begin
                            r_halt    <= is_step && d_halt;
                            r_arrived <= 1'b0;
                            r_done    <= 1'b1;
                        end
                    end
                end
                S_DIFF: begin
                    r_ax    <= ax[RAD_W-1:0];
                    r_ay    <= ay[RAD_W-1:0];
                    r_near  <= (ax[DW-1:RAD_W] == '0) && (ay[DW-1:RAD_W] == '0);
                    r_mcnt  <= '0;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    unique case (r_mcnt)
                        2'd0:    r_sq <= {1'b0, prod};
                        2'd1:    r_sq <= r_sq + {1'b0, prod};
                        2'd2:    r_r2 <= prod;
                        default: r_r2 <= r_r2;
                    endcase
                    if (r_mcnt != 2'd3) r_mcnt <= r_mcnt + 1'b1;
                    if (cres.done) begin
                        r_heading <= cres.heading;
                        r_pc      <= n_pc;
                        r_sc      <= n_sc;
                        r_phase   <= n_phase;
                        r_halt    <= 1'b0;
                        r_arrived <= arr;
                        r_done    <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy            = (r_state != S_IDLE);
    assign o_done            = r_done;
    assign o_heading         = r_heading;
    assign o_halt            = r_halt;
    assign o_arrived         = r_arrived;
    assign o_leg_phase       = r_phase;
    assign o_primary_index   = r_pc;
    assign o_secondary_index = r_sc;

endmodule

// ===== sv/wrf_checker.sv =====
// ----------------------------------------------------------------------------
// wrf_checker
// Port-level checks of the waypoint route follower, bound to the top level.
// ----------------------------------------------------------------------------
module wrf_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_start,
    input logic                       o_busy,
    input logic                       o_done,
    input logic [wrf_pkg::HEAD_W-1:0] o_heading,
    input logic                       o_halt,
    input logic                       o_arrived,
    input logic [wrf_pkg::IDX_W-1:0]  o_primary_index
);
    import wrf_pkg::*;

    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_rst_n)) |-> $past(o_busy || i_start))
        else $error("result word without an accepted item");

    a_halt_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_halt) |-> !o_arrived)
        else $error("halt and arrived together");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_heading < HEADING_WRAP))
        else $error("heading out of range");

    a_cursor_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (o_primary_index != $past(o_primary_index))) |-> o_done)
        else $error("primary cursor changed without a result word");

endmodule

bind waypoint_route_follower_top wrf_checker u_wrf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (i_start),
    .o_busy          (o_busy),
    .o_done          (o_done),
    .o_heading       (o_heading),
    .o_halt          (o_halt),
    .o_arrived       (o_arrived),
    .o_primary_index (o_primary_index)
);

// ===== tb/tb_waypoint_route_follower_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_waypoint_route_follower_top
// Self-checking bench for the waypoint route follower: loads both tables,
// steps positions near and far from waypoints under every route mode and
// checks every result word against a cycle-free route predictor.
// ----------------------------------------------------------------------------
module tb_waypoint_route_follower_top;
    import wrf_pkg::*;

    typedef struct {
        bit [HEAD_W-1:0] heading;
        bit              halt;
        bit              arrived;
        bit [1:0]        phase;
        bit [IDX_W-1:0]  pri_idx;
        bit [IDX_W-1:0]  sec_idx;
    } t_route_word;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_start;
    logic                o_busy;
    logic [1:0]          i_operation;
    logic [CFG_W-1:0]    i_slot;
    logic signed [23:0]  i_east_mm;
    logic signed [23:0]  i_north_mm;
    logic                i_cfg_we;
    logic [2:0]          i_cfg_index;
    logic [RAD_W-1:0]    i_cfg_data;
    logic                o_done;
    logic [HEAD_W-1:0]   o_heading;
    logic                o_halt;
    logic                o_arrived;
    logic [1:0]          o_leg_phase;
    logic [IDX_W-1:0]    o_primary_index;
    logic [IDX_W-1:0]    o_secondary_index;

    waypoint_route_follower_top dut (.*);

    // predictor state
    longint         wp_east [2][64];
    longint         wp_north[2][64];
    bit             wp_loaded[2][64];
    bit [IDX_W-1:0] pri_cursor, sec_cursor;
    bit [1:0]       leg;
    bit [HEAD_W-1:0] last_heading;
    bit [1:0]       cfg_mode;
    bit [5:0]       cfg_pfirst, cfg_plast, cfg_switch, cfg_sfirst, cfg_slast;
    bit [15:0]      cfg_prad, cfg_srad;

    // target of the last probed step: tgt_tab < 0 means no steering
    int             tgt_tab, tgt_idx;

    t_route_word    pending_words[$];
    int             errors;
    int             n_items, n_steps, n_arrivals, n_halts;
    int             gap_pct;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Timeout waiting for results");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic bit [HEAD_W-1:0] cordic_heading(input longint dx, input longint dy);
        longint x, y, acc, xs, ys;
        longint h;
        if (dx == 0 && dy == 0) return '0;
        x = dx * 64'sd16777216;
        y = dy * 64'sd16777216;
        acc = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            acc = 180 * 16384;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; acc = acc + longint'(ATAN_UNITS[i]);
            end else begin
                x = x - ys; y = y + xs; acc = acc - longint'(ATAN_UNITS[i]);
            end
        end
        if (acc < 0) acc = acc + 360 * 16384;
        h = (acc + 128) >> 8;
        if (h >= 23040) h = h - 23040;
        return h[HEAD_W-1:0];
    endfunction

    function automatic bit steer_to(input int tab, input int idx, input longint px,
                                    input longint py, input bit [15:0] radius,
                                    inout bit [HEAD_W-1:0] hd);
        longint dx, dy;
        tgt_tab = tab;
        tgt_idx = idx;
        dx = wp_east[tab][idx] - px;
        dy = wp_north[tab][idx] - py;
        hd = cordic_heading(dx, dy);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (dx >= 65536 || dy >= 65536) return 1'b0;
        return dx * dx + dy * dy < longint'(radius) * longint'(radius);
    endfunction

    // Computes the result of one word; state is updated only when commit is set.
    function automatic t_route_word route_predict(input bit commit, input bit [1:0] op,
                                                  input bit [5:0] slot,
                                                  input logic signed [23:0] e,
                                                  input logic signed [23:0] n);
        t_route_word     w;
        bit [IDX_W-1:0]  pc, sc;
        bit [1:0]        ph;
        bit [HEAD_W-1:0] hd;
        bit              halt, arr;
        longint          px, py;
        pc = pri_cursor; sc = sec_cursor; ph = leg; hd = last_heading;
        halt = 0; arr = 0;
        px = longint'(e); py = longint'(n);
        tgt_tab = -1;
        if (op == OP_LOAD_PRI || op == OP_LOAD_SEC) begin
            if (commit) begin
                wp_east[op][slot] = px;
                wp_north[op][slot] = py;
                wp_loaded[op][slot] = 1'b1;
            end
        end else if (op == OP_STEP) begin
            if (cfg_mode == MODE_PRI) begin
                if (pc > cfg_plast) halt = 1;
                else if (cfg_pfirst < cfg_plast) begin
                    arr = steer_to(0, int'(pc), px, py, cfg_prad, hd);
                    if (arr && pc < cfg_plast) pc++;
                end
            end else if (cfg_mode == MODE_SEC) begin
                if (sc > cfg_slast) halt = 1;
                else if (cfg_sfirst < cfg_slast) begin
                    arr = steer_to(1, int'(sc), px, py, cfg_srad, hd);
                    if (arr) sc++;
                end
            end else if (pc > cfg_plast && sc > cfg_slast) begin
                halt = 1;
            end else if (ph == PH_PRI) begin
                if (pc <= cfg_switch) begin
                    arr = steer_to(0, int'(pc), px, py, cfg_prad, hd);
                    if (arr) begin
                        if (pc == cfg_switch) begin
                            ph = PH_SEC;
                            sc = IDX_W'(cfg_sfirst);
                        end
                        pc++;
                    end
                end else halt = 1;
            end else if (ph == PH_SEC) begin
                if (sc <= cfg_slast) begin
                    arr = steer_to(1, int'(sc), px, py, cfg_srad, hd);
                    if (arr) begin
                        sc++;
                        if (sc > cfg_slast) begin
                            ph = PH_RET;
                            pc = IDX_W'(cfg_switch) + 1'b1;
                        end
                    end
                end else halt = 1;
            end else begin
                if (pc <= cfg_plast) begin
                    arr = steer_to(0, int'(pc), px, py, cfg_prad, hd);
                    if (arr) pc++;
                end else halt = 1;
            end
        end
        if (commit) begin
            pri_cursor = pc; sec_cursor = sc; leg = ph; last_heading = hd;
        end
        w.heading = hd; w.halt = halt; w.arrived = arr;
        w.phase = ph; w.pri_idx = pc; w.sec_idx = sc;
        return w;
    endfunction

    task automatic send_word(input bit [1:0] op, input bit [5:0] slot,
                             input logic signed [23:0] e, input logic signed [23:0] n);
        t_route_word w;
        int gap;
        if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            i_start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_start = 1'b1;
        i_operation = op;
        i_slot = slot;
        i_east_mm = e;
        i_north_mm = n;
        do @(posedge i_clk); while (o_busy);
        w = route_predict(1'b1, op, slot, e, n);
        pending_words.push_back(w);
        n_items++;
        if (op == OP_STEP) n_steps++;
        if (w.arrived) n_arrivals++;
        if (w.halt) n_halts++;
    endtask

    // A step toward an entry that was never loaded is preceded by a random load of it.
    task automatic send_step(input logic signed [23:0] e, input logic signed [23:0] n);
        t_route_word w;
        w = route_predict(1'b0, OP_STEP, '0, e, n);
        if (tgt_tab >= 0 && !wp_loaded[tgt_tab][tgt_idx])
            send_word(tgt_tab[1:0], tgt_idx[5:0], 24'($urandom), 24'($urandom));
        send_word(OP_STEP, '0, e, n);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_start = 1'b0;
        while (pending_words.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic write_reg(input bit [2:0] idx, input bit [15:0] value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        @(posedge i_clk);
        case (idx)
            REG_MODE:      cfg_mode = value[1:0];
            REG_PRI_FIRST: cfg_pfirst = value[5:0];
            REG_PRI_LAST:  cfg_plast = value[5:0];
            REG_SWITCH:    cfg_switch = value[5:0];
            REG_SEC_FIRST: cfg_sfirst = value[5:0];
            REG_SEC_LAST:  cfg_slast = value[5:0];
            REG_PRI_RAD:   cfg_prad = value;
            REG_SEC_RAD:   cfg_srad = value;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic configure(input bit [1:0] mode, input bit [5:0] pf, input bit [5:0] pl,
                             input bit [5:0] sw, input bit [5:0] sf, input bit [5:0] sl,
                             input bit [15:0] pr, input bit [15:0] sr);
        wait_idle();
        write_reg(REG_MODE, 16'(mode));
        write_reg(REG_PRI_FIRST, 16'(pf));
        write_reg(REG_PRI_LAST, 16'(pl));
        write_reg(REG_SWITCH, 16'(sw));
        write_reg(REG_SEC_FIRST, 16'(sf));
        write_reg(REG_SEC_LAST, 16'(sl));
        write_reg(REG_PRI_RAD, pr);
        write_reg(REG_SEC_RAD, sr);
    endtask

    // Position close to the waypoint the next step will steer toward.
    task automatic step_near();
        t_route_word w;
        int r, ox, oy;
        longint bx, by;
        w = route_predict(1'b0, OP_STEP, '0, '0, '0);
        if (tgt_tab < 0 || !wp_loaded[tgt_tab][tgt_idx]) begin
            send_step(24'($urandom), 24'($urandom));
            return;
        end
        r = (tgt_tab == 0) ? int'(cfg_prad) : int'(cfg_srad);
        r = r + 2;
        ox = int'($urandom_range(0, r)) - r / 2;
        oy = int'($urandom_range(0, r)) - r / 2;
        bx = wp_east[tgt_tab][tgt_idx];
        by = wp_north[tgt_tab][tgt_idx];
        send_step(24'(bx + ox), 24'(by + oy));
    endtask

    task automatic random_word();
        int k;
        k = $urandom_range(99);
        if (k < 12)
            send_word(2'($urandom_range(1)), 6'($urandom), 24'($urandom), 24'($urandom));
        else if (k < 16)
            send_word(2'($urandom_range(1)), 6'($urandom),
                      24'($urandom_range(0, 40000) - 20000),
                      24'($urandom_range(0, 40000) - 20000));
        else if (k < 18)
            send_word(OP_NOP, 6'($urandom), 24'($urandom), 24'($urandom));
        else if (k < 30)
            send_step(24'($urandom), 24'($urandom));
        else
            step_near();
    endtask

    task automatic random_config();
        bit [5:0] pf, pl, sw, sf, sl;
        bit [15:0] pr, sr;
        pf = 6'($urandom_range(0, 20));
        pl = ($urandom_range(9) == 0) ? 6'd63 : 6'($urandom_range(0, 40));
        sw = 6'($urandom_range(0, 40));
        sf = 6'($urandom_range(0, 20));
        sl = ($urandom_range(9) == 0) ? 6'd63 : 6'($urandom_range(0, 40));
        pr = ($urandom_range(5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
        sr = ($urandom_range(5) == 0) ? 16'hFFFF : 16'($urandom_range(0, 3000));
        configure(2'($urandom_range(0, 2)), pf, pl, sw, sf, sl, pr, sr);
    endtask

    task automatic test_table_loads();
        send_word(OP_LOAD_PRI, 6'd0, 24'sd0, 24'sd0);
        send_word(OP_LOAD_PRI, 6'd63, 24'h7FFFFF, 24'h800000);
        send_word(OP_LOAD_SEC, 6'd0, 24'h800000, 24'h7FFFFF);
        send_word(OP_LOAD_SEC, 6'd63, -24'sd1, -24'sd1);
        send_word(OP_NOP, 6'd63, 24'h7FFFFF, 24'h7FFFFF);
    endtask

    task automatic test_directed_steps();
        // default registers: combined, zero ranges
        send_step(24'sd0, 24'sd0);
        configure(MODE_PRI, 6'd0, 6'd2, 6'd0, 6'd0, 6'd3, 16'd0, 16'hFFFF);
        send_word(OP_LOAD_PRI, 6'd1, 24'sd1000, 24'sd1000);
        send_word(OP_LOAD_PRI, 6'd2, -24'sd5000, 24'sd0);
        send_step(24'h7FFFFF, 24'h7FFFFF);
        send_step(24'h800000, 24'h800000);
        send_step(24'sd0, -24'sd1000);
        send_step(24'sd0, 24'sd0);
        configure(MODE_PRI, 6'd0, 6'd2, 6'd0, 6'd0, 6'd3, 16'hFFFF, 16'hFFFF);
        send_step(24'sd10, 24'sd0);
        send_step(24'sd1000, 24'sd1000);
        send_step(-24'sd5000, 24'sd0);
        send_step(-24'sd5000, 24'sd0);
        configure(MODE_SEC, 6'd5, 6'd5, 6'd0, 6'd0, 6'd1, 16'd1000, 16'd100);
        send_step(24'h800000, 24'sd0);
        send_step(24'sd0, 24'sd50);
        send_step(24'sd0, 24'sd0);
        send_step(24'sd0, 24'sd0);
        send_step(24'sd7, 24'sd7);
        configure(MODE_DUAL_ALT, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 16'd1000, 16'd100);
        send_step(24'sd3, 24'sd4);
        send_step(24'sd0, 24'sd0);
    endtask

    task automatic test_random_phase(input int pct, input int words);
        gap_pct = pct;
        for (int i = 0; i < words; i++) begin
            if (i % 110 == 0) random_config();
            random_word();
        end
        gap_pct = 0;
    endtask

    always @(posedge i_clk) begin
        t_route_word w;
        if (i_rst_n && o_done) begin
            if (pending_words.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                w = pending_words.pop_front();
                if (o_heading !== w.heading) begin
                    $error("heading: expected %0d, got %0d", w.heading, o_heading);
                    errors++;
                end
                if (o_halt !== w.halt) begin
                    $error("halt: expected %0d, got %0d", w.halt, o_halt);
                    errors++;
                end
                if (o_arrived !== w.arrived) begin
                    $error("arrived: expected %0d, got %0d", w.arrived, o_arrived);
                    errors++;
                end
                if (o_leg_phase !== w.phase) begin
                    $error("leg_phase: expected %0d, got %0d", w.phase, o_leg_phase);
                    errors++;
                end
                if (o_primary_index !== w.pri_idx) begin
                    $error("primary_index: expected %0d, got %0d", w.pri_idx, o_primary_index);
                    errors++;
                end
                if (o_secondary_index !== w.sec_idx) begin
                    $error("secondary_index: expected %0d, got %0d", w.sec_idx,
                           o_secondary_index);
                    errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_operation = '0;
        i_slot = '0;
        i_east_mm = '0;
        i_north_mm = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        errors = 0;
        n_items = 0; n_steps = 0; n_arrivals = 0; n_halts = 0;
        gap_pct = 0;
        pri_cursor = '0; sec_cursor = '0; leg = PH_PRI; last_heading = '0;
        cfg_mode = MODE_DUAL; cfg_pfirst = '0; cfg_plast = '0; cfg_switch = '0;
        cfg_sfirst = '0; cfg_slast = '0; cfg_prad = 16'd1000; cfg_srad = 16'd100;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_table_loads();
        test_directed_steps();
        test_random_phase(0, 340);
        test_random_phase(62, 330);
        test_random_phase(0, 330);
        test_random_phase(6, 330);
        wait_idle();

        $display("Covered %0d words: %0d steps, %0d arrivals, %0d halts, final leg %0d",
                 n_items, n_steps, n_arrivals, n_halts, leg);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
